// ===== hw/rtl/cvt_pkg.sv =====
// Shared constants, types and helper functions of the cardinality violation tracker.
`default_nettype none
package cvt_pkg;

  localparam int VALUE_SLOTS = 64;
  localparam int NUM_VARS    = 256;
  localparam int SLOT_W      = $clog2(VALUE_SLOTS);
  localparam int VAR_W       = $clog2(NUM_VARS);
  localparam int VAL_W       = 32;
  localparam int BND_W       = 10;
  localparam int CNT_W       = 9;
  localparam int SHORT_W     = 15;
  localparam int EXCESS_W    = 9;
  localparam int CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    OP_SET_BOUND = 2'd0,
    OP_ASSIGN    = 2'd1,
    OP_CLEAR     = 2'd2,
    OP_NONE      = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOSED_MODE  = 2'd0,
    REG_LOWEST_VALUE = 2'd1,
    REG_UNUSED_2     = 2'd2,
    REG_UNUSED_3     = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RD_SB  = 2'd0,
    RD_OLD = 2'd1,
    RD_NEW = 2'd2,
    RD_NA  = 2'd3
  } rd_sel_t;

  typedef struct packed {
    logic    latch;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    upd_sb;
    logic    upd_dec;
    logic    upd_inc;
    logic    var_wr;
    logic    clear;
    logic    load_out;
  } cvt_cmd_t;

  typedef struct packed {
    opcode_t op_in;
    logic    sb_hit;
    logic    assigned;
    logic    same_val;
    logic    out_busy;
  } cvt_sts_t;

  // Signed distance of a value from the slot below the covered range.
  function automatic logic signed [VAL_W+1:0] slot_offset(
    input logic [VAL_W-1:0] val,
    input logic [VAL_W-1:0] lowest
  );
    slot_offset = $signed({{2{val[VAL_W-1]}}, val}) - $signed({{2{lowest[VAL_W-1]}}, lowest})
                  + $signed((VAL_W+2)'(1));
  endfunction

  // Slot of a value, with out-of-range values clamped onto the edge slots.
  function automatic logic [SLOT_W-1:0] slot_of(
    input logic [VAL_W-1:0] val,
    input logic [VAL_W-1:0] lowest
  );
    logic signed [VAL_W+1:0] d;
    d = slot_offset(val, lowest);
    if (d < 0) slot_of = '0;
    else if (d > $signed((VAL_W+2)'(VALUE_SLOTS - 1))) slot_of = SLOT_W'(VALUE_SLOTS - 1);
    else slot_of = d[SLOT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cardinality_violation_tracker.sv =====
// Top level of the cardinality violation tracker: controller plus datapath.
`default_nettype none
// The tracker keeps, for up to 256 variables, the value each one holds and a
// count of variables in each of 64 value slots, each slot with a lower and an
// upper bound, and reports after every input transaction the shortage total,
// the excess total and the violation (the larger of the two). Each input
// transaction yields exactly one output transaction. Transactions are handled
// one at a time by a state machine that walks the slot and variable memories,
// each of which has one read and one write port with registered read data.
// A clear or an undefined opcode goes straight to the done step, a set_bound
// reads and rewrites its slot unless the value lies outside the settable
// slots, and an assign reads the variable and then finishes for an unchanged
// value, adds a first assignment to its slot, or moves the variable between
// slots (the old slot is read and rewritten before the new slot is read). A
// finished result sits in the output register, and the next transaction is
// accepted while it waits; it then holds in its last step until the output is
// free. Writing either configuration register reloads every slot with the
// mode default bounds and clears all counts, assignments and totals. Writes
// are only to be made while the block is idle; the block does not enforce it.
module cardinality_violation_tracker (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write_en,
  input  wire logic [cvt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [cvt_pkg::VAL_W-1:0]            cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           opcode,
  input  wire logic [cvt_pkg::VAR_W-1:0]            var_index,
  input  wire logic signed [cvt_pkg::VAL_W-1:0]     value,
  input  wire logic signed [cvt_pkg::BND_W-1:0]     lower_bound,
  input  wire logic signed [cvt_pkg::BND_W-1:0]     upper_bound,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [cvt_pkg::SHORT_W-1:0]               violation,
  output logic [cvt_pkg::SHORT_W-1:0]               shortage_total,
  output logic [cvt_pkg::EXCESS_W-1:0]              excess_total
);

  cvt_pkg::cvt_cmd_t cmd;
  cvt_pkg::cvt_sts_t sts;

  // The controller sequences the memory accesses of each transaction.
  cvt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // The datapath holds all state, the running totals and the result register.
  cvt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .opcode(opcode), .var_index(var_index), .value(value),
    .lower_bound(lower_bound), .upper_bound(upper_bound),
    .cfg_write_en(cfg_write_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall), .violation(violation),
    .shortage_total(shortage_total), .excess_total(excess_total)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/cvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cvt_ctrl.sv =====
// Controller state machine that sequences each transaction through the datapath.
`default_nettype none
module cvt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cvt_pkg::cvt_sts_t sts,
  output cvt_pkg::cvt_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SB_RD, S_SB_WR, S_VAR, S_OLD, S_NRD, S_NEW, S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.rd_sel = cvt_pkg::RD_SB;
    cmd.latch  = accept;
    case (state)
      S_SB_RD: begin
        cmd.rd_en  = sts.sb_hit;
        cmd.rd_sel = cvt_pkg::RD_SB;
      end
      S_SB_WR: cmd.upd_sb = 1'b1;
      S_VAR: begin
        cmd.rd_en  = !(sts.assigned && sts.same_val);
        cmd.rd_sel = sts.assigned ? cvt_pkg::RD_OLD : cvt_pkg::RD_NEW;
      end
      S_OLD: cmd.upd_dec = 1'b1;
      S_NRD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = cvt_pkg::RD_NEW;
      end
      S_NEW: begin
        cmd.upd_inc = 1'b1;
        cmd.var_wr  = 1'b1;
      end
      S_DONE: cmd.load_out = !sts.out_busy;
      default: ;
    endcase
    if (state == S_IDLE && accept && sts.op_in == cvt_pkg::OP_CLEAR) begin
      cmd.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (sts.op_in)
              cvt_pkg::OP_SET_BOUND: state <= S_SB_RD;
              cvt_pkg::OP_ASSIGN:    state <= S_VAR;
              default:               state <= S_DONE;
            endcase
          end
        end
        S_SB_RD: state <= sts.sb_hit ? S_SB_WR : S_DONE;
        S_SB_WR: state <= S_DONE;
        S_VAR: begin
          if (!sts.assigned) state <= S_NEW;
          else if (sts.same_val) state <= S_DONE;
          else state <= S_OLD;
        end
        S_OLD:  state <= S_NRD;
        S_NRD:  state <= S_NEW;
        S_NEW:  state <= S_DONE;
        S_DONE: if (!sts.out_busy) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_update: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.upd_sb, cmd.upd_dec, cmd.upd_inc, cmd.load_out}) <= 1)
    else $error("more than one datapath update in a cycle");
  a_dec_then_inc: assert property (@(posedge clk) disable iff (rst)
    cmd.upd_dec |=> ##1 cmd.upd_inc)
    else $error("old slot drop not followed by new slot add");
  a_var_write_last: assert property (@(posedge clk) disable iff (rst)
    cmd.var_wr |=> (state == S_DONE))
    else $error("variable write not followed by completion");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/cvt_datapath.sv =====
// Datapath: slot stores, variable store, running totals and result register.
`default_nettype none
module cvt_datapath (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire cvt_pkg::cvt_cmd_t                    cmd,
  output cvt_pkg::cvt_sts_t                         sts,
  input  wire logic [1:0]                           opcode,
  input  wire logic [cvt_pkg::VAR_W-1:0]            var_index,
  input  wire logic signed [cvt_pkg::VAL_W-1:0]     value,
  input  wire logic signed [cvt_pkg::BND_W-1:0]     lower_bound,
  input  wire logic signed [cvt_pkg::BND_W-1:0]     upper_bound,
  input  wire logic                                 cfg_write_en,
  input  wire logic [cvt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [cvt_pkg::VAL_W-1:0]            cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [cvt_pkg::SHORT_W-1:0]               violation,
  output logic [cvt_pkg::SHORT_W-1:0]               shortage_total,
  output logic [cvt_pkg::EXCESS_W-1:0]              excess_total
);

  localparam int BW = cvt_pkg::BND_W;
  localparam int CW = cvt_pkg::CNT_W;
  localparam int SW = cvt_pkg::SHORT_W;
  localparam int EW = cvt_pkg::EXCESS_W;

  // Configuration registers.
  logic                        closed_mode;
  logic [cvt_pkg::VAL_W-1:0]   lowest_value;

  // Latched transaction fields.
  logic [cvt_pkg::VAR_W-1:0]   vi_q;
  logic [cvt_pkg::VAL_W-1:0]   val_q;
  logic signed [BW-1:0]        lo_q;
  logic signed [BW-1:0]        up_q;

  logic [cvt_pkg::VALUE_SLOTS-1:0] bnd_valid;
  logic [cvt_pkg::VALUE_SLOTS-1:0] cnt_valid;
  logic [cvt_pkg::NUM_VARS-1:0]    assigned;

  logic [SW-1:0] shortage_sum;
  logic [SW-1:0] base_sum;
  logic [EW-1:0] excess_sum;

  logic [cvt_pkg::SLOT_W-1:0] rd_addr;
  logic [cvt_pkg::SLOT_W-1:0] cur_slot;
  logic                       rd_bvalid;
  logic                       rd_cvalid;
  logic [2*BW-1:0]            bnd_rdata;
  logic [2*BW-1:0]            bnd_wdata;
  logic [CW-1:0]              cnt_rdata;
  logic [cvt_pkg::VAL_W-1:0]  var_rdata;

  logic signed [cvt_pkg::VAL_W+1:0] sb_off;
  logic signed [BW-1:0] dflt;
  logic signed [BW-1:0] lo_o, up_o, lo_n, up_n;
  logic [CW-1:0]        c_o, c_n;
  logic [BW-1:0]        sh_o, sh_n, pos_o, pos_n;
  logic [EW-1:0]        ex_o, ex_n;
  logic                 upd;
  logic                 cfg_hit;

  function automatic logic [BW-1:0] short_of(input logic signed [BW-1:0] lo,
                                             input logic [CW-1:0] c);
    logic signed [BW:0] d;
    d = $signed({lo[BW-1], lo}) - $signed({1'b0, c});
    short_of = (!lo[BW-1] && d > 0) ? d[BW-1:0] : '0;
  endfunction

  function automatic logic [EW-1:0] excess_of(input logic signed [BW-1:0] lo,
                                              input logic signed [BW-1:0] up,
                                              input logic [CW-1:0] c);
    logic signed [BW:0] d;
    d = $signed({1'b0, c}) - $signed({up[BW-1], up});
    excess_of = (!lo[BW-1] && d > 0) ? d[EW-1:0] : '0;
  endfunction

  assign sb_off = cvt_pkg::slot_offset(val_q, lowest_value);

  always_comb begin
    case (cmd.rd_sel)
      cvt_pkg::RD_OLD: rd_addr = cvt_pkg::slot_of(var_rdata, lowest_value);
      cvt_pkg::RD_NEW: rd_addr = cvt_pkg::slot_of(val_q, lowest_value);
      default:         rd_addr = sb_off[cvt_pkg::SLOT_W-1:0];
    endcase
  end

  cvt_ram #(.WIDTH(2 * BW), .DEPTH(cvt_pkg::VALUE_SLOTS)) u_bnd_ram (
    .clk(clk), .we(cmd.upd_sb), .waddr(cur_slot), .wdata(bnd_wdata),
    .raddr(rd_addr), .rdata(bnd_rdata)
  );

  cvt_ram #(.WIDTH(CW), .DEPTH(cvt_pkg::VALUE_SLOTS)) u_cnt_ram (
    .clk(clk), .we(cmd.upd_dec || cmd.upd_inc), .waddr(cur_slot), .wdata(c_n),
    .raddr(rd_addr), .rdata(cnt_rdata)
  );

  cvt_ram #(.WIDTH(cvt_pkg::VAL_W), .DEPTH(cvt_pkg::NUM_VARS)) u_var_ram (
    .clk(clk), .we(cmd.var_wr), .waddr(vi_q), .wdata(val_q),
    .raddr(var_index), .rdata(var_rdata)
  );

  // Slots never written hold the mode default bounds and a zero count.
  always_comb begin
    dflt = closed_mode ? '0 : '1;
    lo_o = rd_bvalid ? $signed(bnd_rdata[2*BW-1:BW]) : dflt;
    up_o = rd_bvalid ? $signed(bnd_rdata[BW-1:0]) : dflt;
    c_o  = rd_cvalid ? cnt_rdata : '0;
    lo_n = lo_o;
    up_n = up_o;
    c_n  = c_o;
    if (cmd.upd_sb) begin
      if (lo_q[BW-1]) begin
        lo_n = '1;
        up_n = '1;
      end else begin
        lo_n = lo_q;
        up_n = (up_q < lo_q) ? lo_q : up_q;
      end
    end else if (cmd.upd_dec) begin
      c_n = (c_o == '0) ? c_o : c_o - CW'(1);
    end else if (cmd.upd_inc) begin
      c_n = c_o + CW'(1);
    end
    sh_o  = short_of(lo_o, c_o);
    sh_n  = short_of(lo_n, c_n);
    ex_o  = excess_of(lo_o, up_o, c_o);
    ex_n  = excess_of(lo_n, up_n, c_n);
    pos_o = lo_o[BW-1] ? '0 : lo_o;
    pos_n = lo_n[BW-1] ? '0 : lo_n;
    bnd_wdata = {lo_n, up_n};
  end

  assign upd     = cmd.upd_sb || cmd.upd_dec || cmd.upd_inc;
  assign cfg_hit = cfg_write_en && (cfg_index == cvt_pkg::REG_CLOSED_MODE ||
                                    cfg_index == cvt_pkg::REG_LOWEST_VALUE);

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      vi_q  <= var_index;
      val_q <= value;
      lo_q  <= lower_bound;
      up_q  <= upper_bound;
    end
    if (cmd.rd_en) begin
      cur_slot  <= rd_addr;
      rd_bvalid <= bnd_valid[rd_addr];
      rd_cvalid <= cnt_valid[rd_addr];
    end
    if (cmd.load_out) begin
      shortage_total <= shortage_sum;
      excess_total   <= excess_sum;
      violation      <= (shortage_sum > SW'(excess_sum)) ? shortage_sum : SW'(excess_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      if (rst) begin
        closed_mode  <= 1'b0;
        lowest_value <= '0;
      end else if (cfg_index == cvt_pkg::REG_CLOSED_MODE) begin
        closed_mode <= cfg_data[0];
      end else begin
        lowest_value <= cfg_data;
      end
      bnd_valid    <= '0;
      cnt_valid    <= '0;
      assigned     <= '0;
      shortage_sum <= '0;
      excess_sum   <= '0;
      base_sum     <= '0;
    end else begin
      if (cmd.clear) begin
        cnt_valid    <= '0;
        assigned     <= '0;
        shortage_sum <= base_sum;
        excess_sum   <= '0;
      end
      if (upd) begin
        shortage_sum <= shortage_sum - SW'(sh_o) + SW'(sh_n);
        excess_sum   <= excess_sum - ex_o + ex_n;
      end
      if (cmd.upd_sb) begin
        bnd_valid[cur_slot] <= 1'b1;
        base_sum <= base_sum - SW'(pos_o) + SW'(pos_n);
      end
      if (cmd.upd_dec || cmd.upd_inc) begin
        cnt_valid[cur_slot] <= 1'b1;
      end
      if (cmd.var_wr) begin
        assigned[vi_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.op_in    = cvt_pkg::opcode_t'(opcode);
    sts.sb_hit   = (sb_off >= $signed((cvt_pkg::VAL_W+2)'(1))) &&
                   (sb_off <= $signed((cvt_pkg::VAL_W+2)'(cvt_pkg::VALUE_SLOTS - 2)));
    sts.assigned = assigned[vi_q];
    sts.same_val = (var_rdata == val_q);
    sts.out_busy = out_valid && out_stall;
  end

`ifndef SYNTHESIS
  a_excess_bounded: assert property (@(posedge clk) disable iff (rst)
    excess_sum <= EW'(cvt_pkg::NUM_VARS))
    else $error("excess sum above the number of variables");
  a_cfg_resets_sums: assert property (@(posedge clk) disable iff (rst)
    cfg_hit |=> (shortage_sum == '0 && excess_sum == '0 && base_sum == '0))
    else $error("configuration write did not reset the totals");
  a_clear_totals: assert property (@(posedge clk) disable iff (rst)
    (cmd.clear && !cfg_hit) |=> (excess_sum == '0 && shortage_sum == base_sum))
    else $error("clear left wrong totals");
`endif

endmodule
`default_nettype wire

// ===== tb/cvt_checker.sv =====
// Checker for the cardinality violation tracker: predicts and compares every result.
module cvt_checker
  import cvt_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [VAL_W-1:0]           cfg_data,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic [1:0]                 opcode,
  input  wire logic [VAR_W-1:0]           var_index,
  input  wire logic signed [VAL_W-1:0]    value,
  input  wire logic signed [BND_W-1:0]    lower_bound,
  input  wire logic signed [BND_W-1:0]    upper_bound,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [SHORT_W-1:0]         violation,
  input  wire logic [SHORT_W-1:0]         shortage_total,
  input  wire logic [EXCESS_W-1:0]        excess_total,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic [SHORT_W-1:0]  vio;
    logic [SHORT_W-1:0]  shortage;
    logic [EXCESS_W-1:0] excess;
  } totals_t;

  logic   closed;
  longint lowest;
  int     bnd_lo [VALUE_SLOTS];
  int     bnd_up [VALUE_SLOTS];
  int     occupancy [VALUE_SLOTS];
  longint holds [NUM_VARS];
  bit     placed [NUM_VARS];
  int     shortage_acc;
  int     excess_acc;
  totals_t totals_q[$];

  function automatic int slot_shortage(int s);
    if (bnd_lo[s] < 0 || bnd_lo[s] <= occupancy[s]) return 0;
    return bnd_lo[s] - occupancy[s];
  endfunction

  function automatic int slot_excess(int s);
    if (bnd_lo[s] < 0 || occupancy[s] <= bnd_up[s]) return 0;
    return occupancy[s] - bnd_up[s];
  endfunction

  function automatic int home_slot(longint v);
    longint d;
    d = v - lowest + 1;
    if (d < 0) return 0;
    if (d > VALUE_SLOTS - 1) return VALUE_SLOTS - 1;
    return int'(d);
  endfunction

  function automatic void unlink(int s);
    shortage_acc -= slot_shortage(s);
    excess_acc   -= slot_excess(s);
  endfunction

  function automatic void relink(int s);
    shortage_acc += slot_shortage(s);
    excess_acc   += slot_excess(s);
  endfunction

  function automatic void wipe_counts();
    for (int s = 0; s < VALUE_SLOTS; s++) occupancy[s] = 0;
    for (int v = 0; v < NUM_VARS; v++) placed[v] = 1'b0;
    shortage_acc = 0;
    excess_acc = 0;
    for (int s = 0; s < VALUE_SLOTS; s++) relink(s);
  endfunction

  task automatic reload_bounds();
    for (int s = 0; s < VALUE_SLOTS; s++) begin
      bnd_lo[s] = closed ? 0 : -1;
      bnd_up[s] = closed ? 0 : -1;
    end
    wipe_counts();
  endtask

  // Applies one input transaction and returns the totals it reports.
  function automatic totals_t track(logic [1:0] op, int vi, longint v, int lo, int up);
    totals_t t;
    longint d;
    int os, ns, peak;
    if (op == OP_SET_BOUND) begin
      d = v - lowest + 1;
      if (d >= 1 && d <= VALUE_SLOTS - 2) begin
        unlink(int'(d));
        if (lo < 0) begin
          bnd_lo[d] = -1;
          bnd_up[d] = -1;
        end else begin
          bnd_lo[d] = lo;
          bnd_up[d] = (up < lo) ? lo : up;
        end
        relink(int'(d));
      end
    end else if (op == OP_ASSIGN) begin
      if (!placed[vi] || holds[vi] != v) begin
        if (placed[vi]) begin
          os = home_slot(holds[vi]);
          unlink(os);
          if (occupancy[os] > 0) occupancy[os]--;
          relink(os);
        end
        ns = home_slot(v);
        unlink(ns);
        occupancy[ns]++;
        relink(ns);
        holds[vi] = v;
        placed[vi] = 1'b1;
      end
    end else if (op == OP_CLEAR) begin
      wipe_counts();
    end
    peak = (shortage_acc > excess_acc) ? shortage_acc : excess_acc;
    t.vio      = (peak > 32767) ? 15'h7fff : SHORT_W'(peak);
    t.shortage = (shortage_acc > 32767) ? 15'h7fff : SHORT_W'(shortage_acc);
    t.excess   = (excess_acc > 511) ? 9'h1ff : EXCESS_W'(excess_acc);
    return t;
  endfunction

  always @(posedge clk) begin
    totals_t want;
    if (rst) begin
      closed = 1'b0;
      lowest = 0;
      reload_bounds();
      totals_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_index == REG_CLOSED_MODE) begin
          closed = cfg_data[0];
          reload_bounds();
        end else if (cfg_index == REG_LOWEST_VALUE) begin
          lowest = longint'($signed(cfg_data));
          reload_bounds();
        end
      end
      if (out_valid && !out_stall) begin
        if (totals_q.size() == 0) begin
          $display("%0t: unexpected result %0d/%0d/%0d", $time,
                   violation, shortage_total, excess_total);
          fail_count++;
        end else begin
          want = totals_q.pop_front();
          if (violation !== want.vio) begin
            $display("%0t: violation expected %0d actual %0d", $time, want.vio, violation);
            fail_count++;
          end
          if (shortage_total !== want.shortage) begin
            $display("%0t: shortage_total expected %0d actual %0d", $time,
                     want.shortage, shortage_total);
            fail_count++;
          end
          if (excess_total !== want.excess) begin
            $display("%0t: excess_total expected %0d actual %0d", $time,
                     want.excess, excess_total);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        totals_q.push_back(track(opcode, int'(var_index), longint'(value),
                                 int'(lower_bound), int'(upper_bound)));
    end
    pending = totals_q.size();
  end

endmodule

// ===== tb/tb_cardinality_violation_tracker.sv =====
// Testbench top of the cardinality violation tracker: stimulus, idling and verdict.
module tb_cardinality_violation_tracker;
  import cvt_pkg::*;

  // Generous bound on the whole run; a correct run needs far fewer cycles.
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VAL_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = OP_NONE;
  logic [VAR_W-1:0] var_index = '0;
  logic signed [VAL_W-1:0] value = '0;
  logic signed [BND_W-1:0] lower_bound = '0;
  logic signed [BND_W-1:0] upper_bound = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SHORT_W-1:0] violation;
  logic [SHORT_W-1:0] shortage_total;
  logic [EXCESS_W-1:0] excess_total;
  int fail_count;
  int pending;
  int cycles = 0;
  // The lowest covered value as currently programmed, used to aim values at slots.
  int lowest_now = 0;

  always #5 clk = ~clk;

  cardinality_violation_tracker dut (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .opcode, .var_index, .value, .lower_bound, .upper_bound,
    .out_valid, .out_stall, .violation, .shortage_total, .excess_total
  );

  cvt_checker u_checker (
    .clk, .rst, .cfg_write_en, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .opcode, .var_index, .value, .lower_bound, .upper_bound,
    .out_valid, .out_stall, .violation, .shortage_total, .excess_total,
    .fail_count, .pending
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver side. Stall density is redrawn periodically and is often zero, so some stretches
  // run with no stall at all. Once, well into the run, the receiver holds off for
  // a long stretch while the sender keeps offering transactions, so the block's
  // output register fills and it has to stall its input.
  initial begin
    int hold_left;
    int pct;
    int tick;
    hold_left = 0;
    pct = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (tick % 300 == 0) pct = (($urandom_range(0, 2)) == 0) ? 0 : $urandom_range(10, 60);
      if (tick == 1500) hold_left = 250;
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if ($urandom_range(0, 99) < pct) begin
        out_stall = 1'b1;
        if ($urandom_range(0, 19) == 0) hold_left = $urandom_range(5, 30);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Offers one transaction after a random gap and waits until it is taken.
  // The stall is looked at on the falling edge, where it is stable until the
  // next rising edge, so a low stall there means the transaction is taken.
  task automatic send(opcode_t op, int vi, int v, int lo, int up);
    int gap;
    gap = ($urandom_range(0, 99) < 70) ? 0 :
          ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    opcode = op;
    var_index = VAR_W'(vi);
    value = v;
    lower_bound = BND_W'(lo);
    upper_bound = BND_W'(up);
    while (in_stall) @(negedge clk);
    @(posedge clk);
  endtask

  // Configuration writes happen only once every expected result is back and the
  // block has had time to settle after its last transaction.
  task automatic write_reg(cfg_reg_t idx, logic [VAL_W-1:0] data);
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (idx == REG_LOWEST_VALUE) lowest_now = data;
  endtask

  function automatic int pick_bound();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return -1;
    if (r < 70) return $urandom_range(0, 4);
    if (r < 90) return $urandom_range(0, 256);
    return 256;
  endfunction

  // Random transaction: mostly assigns of a small pool of variables to values
  // around the covered range, with bound loads mixed in, rare clears and rare undefined opcodes.
  task automatic send_random();
    int r;
    int v;
    int vi;
    r = $urandom_range(0, 99);
    v = ($urandom_range(0, 99) < 85) ? lowest_now + $urandom_range(0, 68) - 3 : $urandom;
    vi = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 23) : $urandom_range(0, 255);
    if (r < 25) send(OP_SET_BOUND, vi, v, pick_bound(), pick_bound());
    else if (r < 93) send(OP_ASSIGN, vi, v, pick_bound(), pick_bound());
    else if (r < 97) send(OP_CLEAR, vi, v, pick_bound(), pick_bound());
    else send(OP_NONE, vi, v, pick_bound(), pick_bound());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, in open mode with the covered range starting at zero.
    send(OP_SET_BOUND, 0, 1, 2, 3);           // restricted slot with room
    send(OP_SET_BOUND, 0, 2, 3, 1);           // upper below lower is raised
    send(OP_SET_BOUND, 0, 3, 256, 256);       // largest bounds the bench drives
    send(OP_SET_BOUND, 0, -1, 1, 1);          // below the cover: ignored
    send(OP_SET_BOUND, 0, 62, 0, 0);          // above the cover: ignored
    send(OP_SET_BOUND, 0, 61, 0, 0);          // last covered slot, tight
    send(OP_ASSIGN, 0, 1, 0, 0);              // first assignment
    send(OP_ASSIGN, 0, 1, 0, 0);              // same value again
    send(OP_ASSIGN, 255, 2, 0, 0);
    send(OP_ASSIGN, 255, 61, 0, 0);           // move between slots
    send(OP_ASSIGN, 7, 61, 0, 0);             // excess on a tight slot
    send(OP_ASSIGN, 8, 32'sh7fffffff, 0, 0);  // clamps to the top edge slot
    send(OP_ASSIGN, 9, 32'sh80000000, 0, 0);  // clamps to the bottom edge slot
    send(OP_ASSIGN, 9, 3, 0, 0);
    send(OP_SET_BOUND, 0, 1, -1, 5);          // negative lower: unrestricted
    send(OP_NONE, 0, 0, 0, 0);                // undefined opcode
    send(OP_CLEAR, 0, 0, 0, 0);               // counts gone, bounds kept
    send(OP_ASSIGN, 0, 2, -1, -1);
    send(OP_ASSIGN, 0, 5, 0, 0);

    // Random phases across register settings, extremes included.
    for (int i = 0; i < 110; i++) send_random();
    write_reg(REG_CLOSED_MODE, 32'hfffffffe | 32'd1);
    write_reg(REG_LOWEST_VALUE, -32'sd5);
    for (int i = 0; i < 110; i++) send_random();
    write_reg(REG_UNUSED_2, $urandom);        // no such register
    for (int i = 0; i < 20; i++) send_random();
    write_reg(REG_CLOSED_MODE, 32'h0);
    write_reg(REG_LOWEST_VALUE, 32'h7fffffff);
    for (int i = 0; i < 100; i++) send_random();
    write_reg(REG_CLOSED_MODE, 32'h1);
    write_reg(REG_LOWEST_VALUE, 32'h80000000);
    for (int i = 0; i < 100; i++) send_random();
    write_reg(REG_CLOSED_MODE, $urandom);
    write_reg(REG_LOWEST_VALUE, $urandom);
    for (int i = 0; i < 100; i++) send_random();

    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== cardinality_violation_tracker.f =====
hw/rtl/cvt_pkg.sv
hw/rtl/cvt_ram.sv
hw/rtl/cvt_ctrl.sv
hw/rtl/cvt_datapath.sv
hw/rtl/cardinality_violation_tracker.sv
tb/cvt_checker.sv
tb/tb_cardinality_violation_tracker.sv
